// ----- sv/lvp_pkg.sv -----
package lvp_pkg;

  localparam int unsigned LINE_CAPACITY = 64;
  localparam int unsigned ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int unsigned LEN_W         = $clog2(LINE_CAPACITY + 1);

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_PLUS    = 8'd43;
  localparam logic [7:0] CH_MINUS   = 8'd45;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;

  localparam logic [2:0] VALUE_LEN  = 3'd5;
  localparam logic [2:0] STATUS_LEN = 3'd6;
  localparam logic [2:0] BODY_MAX   = 3'd7;

  typedef enum logic [1:0] {
    LABEL_NONE   = 2'd0,
    LABEL_VALUE  = 2'd1,
    LABEL_STATUS = 2'd2
  } lvp_label_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } lvp_state_e;

  typedef struct packed {
    logic        is_value;
    logic        is_status;
    logic [31:0] reading;
  } lvp_verdict_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [7:0] value_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h76;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h6c;
      3'd3:    c = 8'h75;
      3'd4:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] status_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h73;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h74;
      3'd4:    c = 8'h75;
      3'd5:    c = 8'h73;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/lvp_line_ram.sv -----
module lvp_line_ram
  import lvp_pkg::*;
(
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0] mem [LINE_CAPACITY];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/lvp_line_scan.sv -----
module lvp_line_scan
  import lvp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         clr_i,
  input  logic         valid_i,
  input  logic [7:0]   data_i,
  output lvp_verdict_t verdict_o
);

  logic [2:0]  k_q, k_d;
  logic        mv_q, mv_d;
  logic        ms_q, ms_d;
  logic        neg_q, neg_d;
  logic        stop_q, stop_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] digit;
  logic        blank;

  assign blank = is_blank(data_i);
  assign digit = {28'd0, data_i[3:0]};

  always_comb begin
    k_d    = k_q;
    mv_d   = mv_q;
    ms_d   = ms_q;
    neg_d  = neg_q;
    stop_d = stop_q;
    acc_d  = acc_q;
    if (clr_i) begin
      k_d    = '0;
      mv_d   = 1'b1;
      ms_d   = 1'b1;
      neg_d  = 1'b0;
      stop_d = 1'b0;
      acc_d  = '0;
    end else if (valid_i && !((k_q == '0) && blank)) begin
      k_d = (k_q == BODY_MAX) ? BODY_MAX : k_q + 3'd1;
      if (k_q < VALUE_LEN) begin
        mv_d = mv_q && (data_i == value_char(k_q));
      end else begin
        mv_d = mv_q && blank;
      end
      if (k_q < STATUS_LEN) begin
        ms_d = ms_q && (data_i == status_char(k_q));
      end else begin
        ms_d = ms_q && blank;
      end
      if (k_q == '0) begin
        if ((data_i == CH_PLUS) || (data_i == CH_MINUS)) begin
          neg_d = (data_i == CH_MINUS);
        end else if (is_digit(data_i)) begin
          acc_d = digit;
        end else begin
          stop_d = 1'b1;
        end
      end else if (!stop_q) begin
        if (is_digit(data_i)) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + digit;
        end else begin
          stop_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      mv_q   <= 1'b1;
      ms_q   <= 1'b1;
      neg_q  <= 1'b0;
      stop_q <= 1'b0;
    end else begin
      k_q    <= k_d;
      mv_q   <= mv_d;
      ms_q   <= ms_d;
      neg_q  <= neg_d;
      stop_q <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign verdict_o.is_value  = mv_q && (k_q >= VALUE_LEN);
  assign verdict_o.is_status = ms_q && (k_q >= STATUS_LEN);
  assign verdict_o.reading   = neg_q ? (32'd0 - acc_q) : acc_q;

endmodule

// ----- sv/labeled_line_value_parser_unit.sv -----
// Channel   | Direction | Payload
// s_axis    | in        | tdata[7:0] rx_byte
// m_axis    | out       | tdata[31:0] touch_status, [63:32] touch_value, [64] forward_touch
// cfg       | in        | cfg_wdata_i forwarding_disabled
//
// A data byte is written into the line memory while fewer than 64 bytes are stored;
// a byte beyond that marks the line as overflowed. A newline is handled in steps:
// the accept, one memory read per stored byte, the scan of the last read data,
// leaving the scan, and applying the line. An overflowed line is dropped.
// A result waits in an output register; a line that changes a reading is applied only once it is free.
// Reset clears control and readings; the line memory content is not cleared.
module labeled_line_value_parser_unit
  import lvp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] touch_status, [63:32] touch_value,
                                      // [64] forward_touch, [71:65] zero
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  lvp_state_e   state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] rd_q, rd_d;
  logic         ovf_q, ovf_d;
  lvp_label_e   label_q, label_d;
  logic [31:0]  status_q, status_d;
  logic [31:0]  value_q, value_d;
  logic         fwd_dis_q;
  logic         out_vld_q, out_vld_d;
  logic [64:0]  out_data_q, out_data_d;
  logic         rvalid_q;
  logic         wr_en, rd_en, scan_clr, accept;
  logic [7:0]   rd_data;
  lvp_verdict_t verdict;
  logic         upd_v, upd_s, out_free;
  logic [31:0]  new_status, new_value;

  lvp_line_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (len_q[ADDR_W-1:0]),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_q[ADDR_W-1:0]),
    .rd_data_o (rd_data)
  );

  lvp_line_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (scan_clr),
    .valid_i   (rvalid_q),
    .data_i    (rd_data),
    .verdict_o (verdict)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_data_q};

  assign upd_v      = (label_q == LABEL_VALUE) && (verdict.reading != value_q);
  assign upd_s      = (label_q == LABEL_STATUS) && (verdict.reading != status_q);
  assign out_free   = !out_vld_q || m_axis_tready;
  assign new_status = upd_s ? verdict.reading : status_q;
  assign new_value  = upd_v ? verdict.reading : value_q;

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    rd_d       = rd_q;
    ovf_d      = ovf_q;
    label_d    = label_q;
    status_d   = status_q;
    value_d    = value_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    scan_clr   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tdata == CH_NEWLINE) begin
            if (ovf_q) begin
              len_d = '0;
              ovf_d = 1'b0;
            end else begin
              rd_d     = '0;
              scan_clr = 1'b1;
              state_d  = ST_SCAN;
            end
          end else if (len_q < LEN_W'(LINE_CAPACITY)) begin
            wr_en = 1'b1;
            len_d = len_q + LEN_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (rd_q < len_q) begin
          rd_en = 1'b1;
          rd_d  = rd_q + LEN_W'(1);
        end else if (!rvalid_q) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (verdict.is_value) begin
          label_d = LABEL_VALUE;
          len_d   = '0;
          state_d = ST_IDLE;
        end else if (verdict.is_status) begin
          label_d = LABEL_STATUS;
          len_d   = '0;
          state_d = ST_IDLE;
        end else if (!((upd_v || upd_s) && !out_free)) begin
          status_d = new_status;
          value_d  = new_value;
          label_d  = LABEL_NONE;
          if (upd_v || upd_s) begin
            out_vld_d  = 1'b1;
            out_data_d = {!fwd_dis_q && !new_status[31] && !new_value[31],
                          new_value, new_status};
          end
          len_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      rd_q      <= '0;
      ovf_q     <= 1'b0;
      label_q   <= LABEL_NONE;
      status_q  <= '0;
      value_q   <= '0;
      fwd_dis_q <= 1'b0;
      out_vld_q <= 1'b0;
      rvalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      rd_q      <= rd_d;
      ovf_q     <= ovf_d;
      label_q   <= label_d;
      status_q  <= status_d;
      value_q   <= value_d;
      out_vld_q <= out_vld_d;
      rvalid_q  <= rd_en;
      if (cfg_we_i) begin
        fwd_dis_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

endmodule

// ----- sv/lvp_checker.sv -----
module lvp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  localparam logic [7:0] NL = 8'd10;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[71:65] == 7'd0))
    else $error("output padding not zero");

  a_fwd_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[64] |-> !m_axis_tdata[31] && !m_axis_tdata[63])
    else $error("forward flag set with a negative reading");

  a_data_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata != NL) && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("output transaction without a line end");

endmodule

bind labeled_line_value_parser_unit lvp_checker u_lvp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
